### rtl/fsmo_pkg.sv
// ----------------------------------------------------------------------------
// fsmo_pkg
// Shared types and constants for the approximate substring matcher.
// ----------------------------------------------------------------------------
package fsmo_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int CHAR_BITS_DEF   = 16;

  localparam int SYM_W   = 16;
  localparam int OP_W    = 2;
  localparam int DIV_W   = 6;
  localparam int FIELD_W = 6;
  localparam int DATA_W  = 16;

  localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } fsmo_op_t;

  // wavefront control handed from cell to cell
  typedef struct packed {
    logic valid;
    logic seen;
    logic has_left;
  } fsmo_ctl_t;

endpackage

### rtl/fsmo_div.sv
// ----------------------------------------------------------------------------
// fsmo_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsmo_div #(
  parameter int NW  = 6,
  parameter int DVW = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [NW-1:0]  quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic            active;
  logic [CNTW-1:0] cnt;
  logic [DVW-1:0]  rem;
  logic [NW-1:0]   quo;
  logic [DVW:0]    trial;
  logic            fits;

  assign trial    = {rem, quo[NW-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNTW'(NW);
      end else if (active) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (active) begin
      if (fits) begin
        rem <= DVW'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DVW-1:0];
      end
      quo <= NW'({quo, fits});
    end
  end

endmodule

### rtl/fsmo_cell.sv
// ----------------------------------------------------------------------------
// fsmo_cell
// One pattern row of the distance column; updates its entry for each text
// character and hands the wavefront to the next row.
// ----------------------------------------------------------------------------
module fsmo_cell #(
  parameter int IDX = 1,
  parameter int DW  = 6,
  parameter int SW  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic                wr_en,
  input  logic [SW-1:0]       wr_sym,
  input  fsmo_pkg::fsmo_ctl_t in_ctl,
  input  logic [SW-1:0]       in_sym,
  input  logic [SW-1:0]       in_psym,
  input  logic [DW-1:0]       in_new,
  input  logic [DW-1:0]       in_old,
  input  logic [DW-1:0]       in_hold,
  input  logic [SW-1:0]       in_pat,
  output fsmo_pkg::fsmo_ctl_t out_ctl,
  output logic [SW-1:0]       out_sym,
  output logic [SW-1:0]       out_psym,
  output logic [DW-1:0]       out_new,
  output logic [DW-1:0]       out_old,
  output logic [DW-1:0]       out_hold,
  output logic [SW-1:0]       out_pat
);

  import fsmo_pkg::*;

  logic [SW-1:0] pat;
  logic [DW-1:0] cur;
  logic [DW-1:0] hold;
  logic [DW:0]   c_up;
  logic [DW:0]   c_left;
  logic [DW:0]   c_diag;
  logic [DW:0]   c_swap;
  logic [DW:0]   m_a;
  logic [DW:0]   m_b;
  logic [DW:0]   m_c;
  logic          trans;
  logic [DW-1:0] d_new;

  assign out_pat = pat;

  always_comb begin
    c_up   = (DW+1)'(cur) + (DW+1)'(1);
    c_left = (DW+1)'(in_new) + (DW+1)'(1);
    c_diag = (DW+1)'(in_old) + (DW+1)'(in_sym != pat);
    c_swap = (DW+1)'(in_hold) + (DW+1)'(1);
    trans  = in_ctl.seen && in_ctl.has_left && (in_sym == in_pat) && (in_psym == pat);
    m_a    = (c_up < c_left) ? c_up : c_left;
    m_b    = (c_diag < m_a) ? c_diag : m_a;
    m_c    = (trans && (c_swap < m_b)) ? c_swap : m_b;
    d_new  = DW'(m_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
      cur     <= DW'(IDX);
      hold    <= DW'(IDX - 1);
    end else begin
      out_ctl.valid    <= in_ctl.valid;
      out_ctl.seen     <= in_ctl.seen;
      out_ctl.has_left <= 1'b1;
      if (restart) begin
        cur  <= DW'(IDX);
        hold <= DW'(IDX - 1);
      end else if (in_ctl.valid) begin
        cur  <= d_new;
        hold <= in_old;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl.valid) begin
      out_new  <= d_new;
      out_old  <= cur;
      out_hold <= hold;
      out_sym  <= in_sym;
      out_psym <= in_psym;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat <= wr_sym;
    end
  end

endmodule

### rtl/fuzzy_substring_match_osa.sv
// ----------------------------------------------------------------------------
// fuzzy_substring_match_osa
// Approximate substring matcher with optimal string alignment distance,
// built as a systolic row of pattern cells.
// ----------------------------------------------------------------------------
// text characters: one per cycle, back to back while no division is running; the
//   wavefront then passes through the cells down to the last active cell
// clear, append and end of text wait until the cell row has drained
// end of text: starts the divider, whose done strobe then sets the registered
//   result valid
// reset: synchronous, empty pattern, divisor 4, columns back to row index
module fuzzy_substring_match_osa #(
  parameter int MAX_PATTERN = fsmo_pkg::MAX_PATTERN_DEF,
  parameter int CHAR_BITS   = fsmo_pkg::CHAR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fsmo_pkg::DATA_W-1:0] s_tdata,   // symbol
  input  logic [fsmo_pkg::OP_W-1:0]   s_tuser,   // opcode
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fsmo_pkg::DATA_W-1:0] m_tdata,   // matched, best_distance, allowed_mistakes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fsmo_pkg::DIV_W-1:0]  cfg_data   // mistake_divisor
);

  import fsmo_pkg::*;

  localparam int SW = (CHAR_BITS < SYM_W) ? CHAR_BITS : SYM_W;
  localparam int DW = $clog2(MAX_PATTERN + 1);
  localparam int CW = $clog2(MAX_PATTERN + 2);

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } state_t;

  state_t             state;
  fsmo_op_t           op;
  logic [SW-1:0]      sym_in;
  logic               take;
  logic               restart;
  logic               wr_en;
  logic               div_start;
  logic               div_done;
  logic [DW-1:0]      div_q;
  logic [DIV_W-1:0]   div_eff;
  logic [DIV_W-1:0]   divisor;
  logic [DW-1:0]      len;
  logic [DW-1:0]      len_next;
  logic [DW-1:0]      best;
  logic               seen;
  logic [SW-1:0]      prev_sym;
  logic [CW-1:0]      drain;
  fsmo_ctl_t          head_ctl;
  logic [SW-1:0]      head_sym;
  logic [SW-1:0]      head_psym;
  logic               hit;
  logic [DW-1:0]      hit_val;
  logic               out_matched;
  logic [FIELD_W-1:0] out_best;
  logic [FIELD_W-1:0] out_allowed;

  fsmo_ctl_t     w_ctl  [0:MAX_PATTERN];
  logic [SW-1:0] w_sym  [0:MAX_PATTERN];
  logic [SW-1:0] w_psym [0:MAX_PATTERN];
  logic [DW-1:0] w_new  [0:MAX_PATTERN];
  logic [DW-1:0] w_old  [0:MAX_PATTERN];
  logic [DW-1:0] w_hold [0:MAX_PATTERN];
  logic [SW-1:0] w_pat  [0:MAX_PATTERN];

  assign cfg_ready = 1'b1;
  assign m_tdata   = DATA_W'({out_allowed, out_best, out_matched});

  always_comb begin
    op        = fsmo_op_t'(s_tuser);
    sym_in    = s_tdata[SW-1:0];
    s_tready  = (state == ST_RUN) &&
                ((op == OP_TEXT) || ((drain == '0) && ((op != OP_END) || !m_tvalid)));
    take      = s_tvalid && s_tready;
    restart   = (take && ((op == OP_CLEAR) || (op == OP_APPEND))) || div_done;
    wr_en     = take && (op == OP_APPEND) && (len < DW'(MAX_PATTERN));
    div_start = take && (op == OP_END);
    div_eff   = (divisor == '0) ? DIV_W'(1) : divisor;
    len_next  = len;
    if (take && (op == OP_CLEAR)) begin
      len_next = '0;
    end else if (wr_en) begin
      len_next = len + DW'(1);
    end
  end

  // head of the wavefront
  assign w_ctl[0]  = head_ctl;
  assign w_sym[0]  = head_sym;
  assign w_psym[0] = head_psym;
  assign w_new[0]  = '0;
  assign w_old[0]  = '0;
  assign w_hold[0] = '0;
  assign w_pat[0]  = '0;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    fsmo_cell #(
      .IDX (g + 1),
      .DW  (DW),
      .SW  (SW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .restart  (restart),
      .wr_en    (wr_en && (len == DW'(g))),
      .wr_sym   (sym_in),
      .in_ctl   (w_ctl[g]),
      .in_sym   (w_sym[g]),
      .in_psym  (w_psym[g]),
      .in_new   (w_new[g]),
      .in_old   (w_old[g]),
      .in_hold  (w_hold[g]),
      .in_pat   (w_pat[g]),
      .out_ctl  (w_ctl[g+1]),
      .out_sym  (w_sym[g+1]),
      .out_psym (w_psym[g+1]),
      .out_new  (w_new[g+1]),
      .out_old  (w_old[g+1]),
      .out_hold (w_hold[g+1]),
      .out_pat  (w_pat[g+1])
    );
  end

  // last pattern row of the wavefront
  always_comb begin
    hit     = 1'b0;
    hit_val = '0;
    for (int g = 1; g <= MAX_PATTERN; g++) begin
      if ((len == DW'(g)) && w_ctl[g].valid) begin
        hit     = 1'b1;
        hit_val = w_new[g];
      end
    end
  end

  fsmo_div #(
    .NW  (DW),
    .DVW (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (len),
    .divisor  (div_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      divisor   <= DIV_RESET;
      len       <= '0;
      best      <= '0;
      seen      <= 1'b0;
      prev_sym  <= '0;
      drain     <= '0;
      head_ctl  <= '0;
      head_sym  <= '0;
      head_psym <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        divisor <= cfg_data;
      end
      head_ctl.valid    <= take && (op == OP_TEXT);
      head_ctl.seen     <= seen;
      head_ctl.has_left <= 1'b0;
      head_sym          <= sym_in;
      head_psym         <= prev_sym;
      if (take && (op == OP_TEXT)) begin
        drain    <= CW'(len) + CW'(1);
        seen     <= 1'b1;
        prev_sym <= sym_in;
      end else if (drain != '0) begin
        drain <= drain - CW'(1);
      end
      if (hit && (hit_val < best)) begin
        best <= hit_val;
      end
      if (restart) begin
        seen     <= 1'b0;
        prev_sym <= '0;
        best     <= len_next;
      end
      len <= len_next;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (div_start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state    <= ST_RUN;
            m_tvalid <= 1'b1;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (div_done) begin
      out_allowed <= FIELD_W'(div_q);
      if (len == '0) begin
        out_matched <= 1'b1;
        out_best    <= '0;
      end else if (!seen) begin
        out_matched <= 1'b0;
        out_best    <= FIELD_W'(len);
      end else begin
        out_matched <= best <= div_q;
        out_best    <= FIELD_W'(best);
      end
    end
  end

  head_hold_during_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> (drain == '0) && !head_ctl.valid)
    else $error("wavefront in flight while dividing");

  result_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DIV)
    else $error("result raised outside end of text");

  best_bounded: assert property (@(posedge clk) disable iff (rst)
    best <= len)
    else $error("best distance above pattern length");

  end_starts_div: assert property (@(posedge clk) disable iff (rst)
    (take && (op == OP_END)) |=> state == ST_DIV)
    else $error("end of text did not start divider");

endmodule

### test/fsmo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmo_checker
// Watches the text, result and divisor channels of the approximate substring
// matcher. It keeps its own copy of the pattern and of the distance columns,
// works out the verdict for every end of text, and compares each result
// transfer field by field with the oldest verdict still waiting.
// ----------------------------------------------------------------------------
module fsmo_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [fsmo_pkg::DATA_W-1:0] s_tdata,   // symbol
  input  logic [fsmo_pkg::OP_W-1:0]   s_tuser,   // opcode
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [fsmo_pkg::DATA_W-1:0] m_tdata,   // matched, best_distance, allowed_mistakes
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [fsmo_pkg::DIV_W-1:0]  cfg_data,  // mistake_divisor
  output int                          fail_count,
  output int                          pending
);

  import fsmo_pkg::*;

  localparam int NCELL = MAX_PATTERN_DEF;

  typedef struct packed {
    logic               matched;
    logic [FIELD_W-1:0] best;
    logic [FIELD_W-1:0] allowed;
  } verdict_t;

  logic [SYM_W-1:0] pat [NCELL];
  int unsigned      plen;
  int unsigned      cur_col [NCELL+1];
  int unsigned      prev_col [NCELL+1];
  logic [SYM_W-1:0] last_sym;
  logic             text_seen;
  int unsigned      best_dist;
  logic [DIV_W-1:0] divisor;
  verdict_t         verdicts [$];
  int               failures;

  initial begin
    failures   = 0;
    foreach (pat[i]) pat[i] = '0;
  end

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic void restart_scan();
    for (int j = 0; j <= NCELL; j++) begin
      cur_col[j]  = j;
      prev_col[j] = j;
    end
    last_sym  = '0;
    text_seen = 1'b0;
    best_dist = plen;
  endfunction

  function automatic void advance_column(logic [SYM_W-1:0] sym);
    int unsigned nxt [NCELL+1];
    int unsigned d;
    nxt[0] = 0;
    for (int j = 1; j <= plen; j++) begin
      d = min_u(cur_col[j] + 1, nxt[j-1] + 1);
      d = min_u(d, cur_col[j-1] + ((sym == pat[j-1]) ? 0 : 1));
      // adjacent transposition
      if (text_seen && j >= 2 && sym == pat[j-2] && last_sym == pat[j-1])
        d = min_u(d, prev_col[j-2] + 1);
      nxt[j] = d;
    end
    best_dist = min_u(best_dist, nxt[plen]);
    for (int j = 0; j <= plen; j++) begin
      prev_col[j] = cur_col[j];
      cur_col[j]  = nxt[j];
    end
    last_sym  = sym;
    text_seen = 1'b1;
  endfunction

  function automatic void predict_item(fsmo_op_t op, logic [SYM_W-1:0] sym);
    verdict_t    v;
    int unsigned dv;
    case (op)
      OP_CLEAR: begin
        plen = 0;
        restart_scan();
      end
      OP_APPEND: begin
        if (plen < NCELL) begin
          pat[plen] = sym;
          plen++;
        end
        restart_scan();
      end
      OP_TEXT: begin
        advance_column(sym);
      end
      default: begin
        dv        = (divisor == 0) ? 1 : divisor;
        v.allowed = FIELD_W'(plen / dv);
        if (plen == 0) begin
          v.matched = 1'b1;
          v.best    = '0;
        end else if (!text_seen) begin
          v.matched = 1'b0;
          v.best    = FIELD_W'(plen);
        end else begin
          v.best    = FIELD_W'(best_dist);
          v.matched = (best_dist <= plen / dv);
        end
        verdicts.push_back(v);
        restart_scan();
      end
    endcase
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst) begin
      plen    = 0;
      divisor = DIV_RESET;
      restart_scan();
      verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        divisor = cfg_data;
      if (m_tvalid && m_tready) begin
        got.matched = m_tdata[0];
        got.best    = m_tdata[FIELD_W:1];
        got.allowed = m_tdata[2*FIELD_W:FIELD_W+1];
        if (verdicts.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with none expected: matched %0d best %0d allowed %0d",
                     $realtime, got.matched, got.best, got.allowed);
        end else begin
          want = verdicts.pop_front();
          if (got.matched !== want.matched || got.best !== want.best ||
              got.allowed !== want.allowed) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch: expected matched %0d best %0d allowed %0d, %s %0d %0d %0d",
                       $realtime, want.matched, want.best, want.allowed,
                       "got", got.matched, got.best, got.allowed);
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_item(fsmo_op_t'(s_tuser), s_tdata);
    end
    fail_count <= failures;
    pending    <= verdicts.size();
  end

endmodule

### test/tb_fuzzy_substring_match_osa.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuzzy_substring_match_osa
// Stimulus for the approximate substring matcher: a short directed run on
// empty patterns, empty text and transpositions, then random patterns with
// edited copies embedded in text, plus noise, over several divisor settings
// and idle patterns on both streams. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_fuzzy_substring_match_osa;
  import fsmo_pkg::*;

  localparam int LIMIT       = 300000;
  localparam int DRAIN       = 100;
  localparam int LONG_STALL  = 400;
  localparam int TOTAL_ITEMS = 1450;
  localparam int SEGMENTS    = 6;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata   = '0;
  logic [OP_W-1:0]   s_tuser   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DIV_W-1:0]  cfg_data  = '0;

  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  bit               stall_req   = 1'b0;
  int               stall_cycles = 0;
  int unsigned      items_sent  = 0;
  logic [SYM_W-1:0] pattern_q [$];
  logic [SYM_W-1:0] text_q [$];
  logic [DIV_W-1:0] divisors [SEGMENTS];

  fuzzy_substring_match_osa DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fsmo_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  always @(posedge clk) begin
    if (stall_req && stall_cycles < LONG_STALL) begin
      m_tready     <= 1'b0;
      stall_cycles <= stall_cycles + 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_item(fsmo_op_t op, logic [SYM_W-1:0] sym);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= sym;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    items_sent++;
    // mirror of the stored pattern, used to build text
    if (op == OP_CLEAR)
      pattern_q.delete();
    else if (op == OP_APPEND && pattern_q.size() < MAX_PATTERN_DEF)
      pattern_q.push_back(sym);
  endtask

  task automatic write_divisor(logic [DIV_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol(bit wide);
    if (wide)
      return SYM_W'($urandom_range(0, 65535));
    return SYM_W'(16'h0041 + $urandom_range(0, 3));
  endfunction

  task automatic random_sequence();
    int unsigned kind;
    int unsigned plen;
    int unsigned i;
    int unsigned r;
    bit          wide;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // noise and broken sequences
      repeat ($urandom_range(1, 8))
        send_item(fsmo_op_t'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 65535)));
      return;
    end
    wide = ($urandom_range(0, 3) == 0);
    if (!(kind < 35 && pattern_q.size() > 0)) begin
      send_item(OP_CLEAR, SYM_W'($urandom_range(0, 65535)));
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 8);
      repeat (plen) send_item(OP_APPEND, pick_symbol(wide));
    end
    text_q.delete();
    r = $urandom_range(0, 9);
    if (r == 0) begin
      // empty text
    end else if (r < 3) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(pick_symbol(wide));
    end else begin
      repeat ($urandom_range(0, 4)) text_q.push_back(pick_symbol(wide));
      i = 0;
      while (i < pattern_q.size()) begin
        case ($urandom_range(0, 9))
          0: ;
          1: text_q.push_back(pick_symbol(wide));
          2: begin
            text_q.push_back(pick_symbol(wide));
            text_q.push_back(pattern_q[i]);
          end
          3: begin
            if (i + 1 < pattern_q.size()) begin
              text_q.push_back(pattern_q[i+1]);
              text_q.push_back(pattern_q[i]);
              i++;
            end else begin
              text_q.push_back(pattern_q[i]);
            end
          end
          default: text_q.push_back(pattern_q[i]);
        endcase
        i++;
      end
      repeat ($urandom_range(0, 4)) text_q.push_back(pick_symbol(wide));
    end
    foreach (text_q[k]) send_item(OP_TEXT, text_q[k]);
    send_item(OP_END, SYM_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    int unsigned seg_target;
    divisors[0] = 6'd1;
    divisors[1] = 6'd32;
    divisors[2] = 6'd0;
    divisors[3] = 6'd63;
    divisors[4] = DIV_W'($urandom_range(2, 31));
    divisors[5] = 6'd2;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset divisor
    send_item(OP_END, 16'hFFFF);
    send_item(OP_TEXT, 16'h0000);
    send_item(OP_END, 16'h0000);
    send_item(OP_APPEND, 16'hFFFF);
    send_item(OP_APPEND, 16'h0000);
    send_item(OP_END, 16'h5A5A);
    send_item(OP_TEXT, 16'h0000);
    send_item(OP_TEXT, 16'hFFFF);
    send_item(OP_END, 16'h0000);
    send_item(OP_TEXT, 16'hFFFF);
    send_item(OP_TEXT, 16'h0000);
    send_item(OP_END, 16'hFFFF);
    send_item(OP_APPEND, 16'h1234);
    send_item(OP_APPEND, 16'h8001);
    send_item(OP_TEXT, 16'h8001);
    send_item(OP_TEXT, 16'h1234);
    send_item(OP_TEXT, 16'h8001);
    send_item(OP_TEXT, 16'h1234);
    send_item(OP_END, 16'h0000);
    send_item(OP_CLEAR, 16'hA5A5);
    send_item(OP_END, 16'h0000);
    wait_idle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 84;
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_divisor(divisors[seg]);
      if (seg == 4) stall_req = 1'b1;
      seg_target = ((seg + 1) * TOTAL_ITEMS) / SEGMENTS;
      while (items_sent < seg_target) random_sequence();
      wait_idle();
    end

    if (pending != 0)
      $display("expected results never delivered: %0d", pending);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/fsmo_pkg.sv
rtl/fsmo_div.sv
rtl/fsmo_cell.sv
rtl/fuzzy_substring_match_osa.sv
test/fsmo_checker.sv
test/tb_fuzzy_substring_match_osa.sv
